// File: hdl/csp_pkg.sv
// Shared types, constants and register indexes for the charger supervisor policy block.
package csp_pkg;

  // Thermistor conversion width; levels and samples compare on these low bits.
  localparam int unsigned AdcBits = 12;
  localparam logic [11:0] AdcMask = 12'((64'd1 << AdcBits) - 64'd1);

  localparam logic [14:0] PortVoltageOkMv = 15'd5000;
  localparam logic [10:0] MaxLimitMa      = 11'd1500;
  localparam logic [10:0] MinLimitMa      = 11'd100;
  localparam logic [8:0]  GadgetMaxMa     = 9'd500;
  localparam logic [8:0]  GadgetFloorMa   = 9'd100;
  // floor(x / 50) == (x * 1311) >> 16 for every x up to 1400.
  localparam logic [10:0] CodeRecip       = 11'd1311;
  localparam int unsigned CodeShift       = 16;

  localparam logic [7:0] DevTypeDcpCdp   = 8'h60;
  localparam logic [3:0] StatusFullCode  = 4'h8;
  localparam logic [3:0] FaultThermal    = 4'h1;
  localparam logic [3:0] FaultOverVolt   = 4'h3;
  localparam logic [3:0] FaultWatchdog   = 4'h5;
  localparam logic [2:0] InputStateA     = 3'h3;
  localparam logic [2:0] InputStateB     = 3'h5;

  typedef enum logic [2:0] {
    CfgColdBlock   = 3'd0,
    CfgColdRelease = 3'd1,
    CfgHotRelease  = 3'd2,
    CfgHotBlock    = 3'd3,
    CfgGadget      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HealthUnknown = 2'd0,
    HealthGood    = 2'd1,
    HealthFail    = 2'd2
  } health_e;

  typedef enum logic [1:0] {
    StDischarging = 2'd0,
    StNotCharging = 2'd1,
    StCharging    = 2'd2,
    StFull        = 2'd3
  } chg_status_e;

  typedef struct packed {
    logic [11:0] cold_block;
    logic [11:0] cold_release;
    logic [11:0] hot_release;
    logic [11:0] hot_block;
    logic [8:0]  gadget_ma;
  } csp_cfg_t;

  typedef struct packed {
    logic        thermal_blocked;
    logic        charge_enabled;
    logic        power_online;
    health_e     health;
    logic [10:0] limit_ma;
    logic        gadget_cleared;
  } csp_state_t;

  typedef struct packed {
    logic        suspended;
    logic        boost_active;
    logic        port_online;
    logic [14:0] port_voltage_mv;
    logic [12:0] port_current_ma;
    logic [7:0]  bc_type;
    logic        adc_valid;
    logic [11:0] adc_sample;
    logic [7:0]  charger_status;
    logic [7:0]  fault_events;
    logic [7:0]  input_state;
  } csp_item_t;

  typedef struct packed {
    logic        online;
    health_e     health;
    logic        charging;
    chg_status_e charge_status;
    logic [10:0] input_limit_ma;
    logic [4:0]  input_limit_code;
    logic        watchdog_kick;
    logic        charge_restart;
  } csp_result_t;

endpackage

// File: hdl/csp_policy.sv
// Combinational policy evaluation of one poll tick against the current state.
module csp_policy
  import csp_pkg::*;
(
  input  csp_item_t   item_i,
  input  csp_cfg_t    cfg_i,
  input  csp_state_t  state_i,
  output csp_state_t  state_o,
  output csp_result_t result_o
);

  logic [10:0] ma;
  logic [10:0] clip_ma;
  logic [8:0]  floor_ma;
  logic [11:0] adc;
  logic [3:0]  ev;
  logic [2:0]  inp;
  logic        enable;
  logic        wd;
  logic        kick;
  logic [10:0] lim;
  logic [10:0] lim_off;
  logic [21:0] code_prod;

  // Allowed input current from the port, charger type and gadget floor.
  always_comb begin
    clip_ma  = (item_i.port_current_ma > 13'(MaxLimitMa)) ? MaxLimitMa
                                                          : item_i.port_current_ma[10:0];
    floor_ma = state_i.gadget_cleared ? 9'd0 : cfg_i.gadget_ma;
    ma       = 11'd0;
    if (item_i.port_online && item_i.port_voltage_mv == PortVoltageOkMv) begin
      ma = clip_ma;
      if ((item_i.bc_type & DevTypeDcpCdp) != 8'd0) begin
        ma = MaxLimitMa;
      end else if (floor_ma > GadgetFloorMa && 11'(floor_ma) > clip_ma) begin
        ma = 11'(floor_ma);
      end
    end
  end

  always_comb begin
    adc     = item_i.adc_sample & AdcMask;
    ev      = item_i.fault_events[3:0];
    inp     = item_i.input_state[6:4];
    state_o = state_i;
    enable  = 1'b0;
    wd      = 1'b0;
    kick    = 1'b0;

    if (!item_i.suspended && !item_i.boost_active) begin
      if (ma == 11'd0) begin
        state_o.gadget_cleared = 1'b1;
      end
      state_o.power_online = (ma != 11'd0);
      if (!item_i.adc_valid) begin
        state_o.health = HealthUnknown;
      end else begin
        // Block test wins over the release window.
        if (adc <= (cfg_i.cold_block & AdcMask) || adc >= (cfg_i.hot_block & AdcMask)) begin
          state_o.thermal_blocked = 1'b1;
        end else if (adc >= (cfg_i.cold_release & AdcMask) &&
                     adc <= (cfg_i.hot_release & AdcMask)) begin
          state_o.thermal_blocked = 1'b0;
        end
        state_o.health       = state_o.thermal_blocked ? HealthFail : HealthGood;
        state_o.power_online = (ma != 11'd0) && item_i.charger_status[7];
        if (state_o.power_online && !state_o.thermal_blocked && ma >= MinLimitMa) begin
          if (ev == FaultThermal || ev == FaultOverVolt) begin
            state_o.health = HealthFail;
          end else begin
            if (ev == FaultWatchdog) begin
              state_o.charge_enabled = 1'b0;
              wd = 1'b1;
            end
            if (inp != InputStateA && inp != InputStateB) begin
              state_o.health = HealthFail;
            end else begin
              enable = 1'b1;
            end
          end
        end
      end
      if (enable) begin
        kick                   = state_o.charge_enabled;
        state_o.charge_enabled = 1'b1;
        state_o.limit_ma       = ma;
      end else begin
        state_o.charge_enabled = 1'b0;
        state_o.limit_ma       = 11'd0;
      end
    end
  end

  // Report fields, taken from the updated state.
  always_comb begin
    lim       = item_i.boost_active ? 11'd0 : state_o.limit_ma;
    lim_off   = lim - MinLimitMa;
    code_prod = 22'(lim_off) * 22'(CodeRecip);

    result_o.online         = state_o.power_online && !item_i.boost_active;
    result_o.health         = state_o.health;
    result_o.charging       = state_o.charge_enabled;
    result_o.input_limit_ma = lim;
    result_o.input_limit_code = (lim >= MinLimitMa) ? code_prod[CodeShift+4:CodeShift] : 5'd0;
    result_o.watchdog_kick  = kick;
    result_o.charge_restart = enable && wd;
    if (item_i.boost_active || !state_o.power_online) begin
      result_o.charge_status = StDischarging;
    end else if (state_o.charge_enabled) begin
      result_o.charge_status = (item_i.charger_status[3:0] == StatusFullCode) ? StFull
                                                                            : StCharging;
    end else begin
      result_o.charge_status = StNotCharging;
    end
  end

endmodule

// File: hdl/charger_supervisor_policy_top.sv
// Top level of the charger supervisor policy block: registers, handshakes and config port.
//
//  Channel  | Direction | Handshake                  | Word
//  ---------+-----------+----------------------------+-------------------------------------
//  in       | input     | in_valid_i / in_stall_o    | one poll tick (status bytes, ADC)
//  out      | output    | out_valid_o / out_stall_i  | one report (health, limit, kick)
//  cfg      | input     | cfg_we_i, cfg_idx_i        | one threshold or gadget floor write
//
// Every accepted word yields exactly one report word. A word lands in the input register,
// is evaluated by one pass of the policy logic and moves into the result register once that
// register is free, from which its report is offered. One word can be accepted in every
// cycle while the output is not stalled, as in_stall_o then stays low.
// The policy state updates in the same cycle the word moves into the result register,
// so the following word already sees it.
// Reset clears the state to thermally blocked, charging off and unknown health, and loads
// the default thresholds. A stall on the output holds the result register and then backs
// up into the input register; in_stall_o rises only when both are full.
module charger_supervisor_policy_top
  import csp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        suspended_i,
  input  logic        boost_active_i,
  input  logic        port_online_i,
  input  logic [14:0] port_voltage_mv_i,
  input  logic [12:0] port_current_ma_i,
  input  logic [7:0]  bc_type_i,
  input  logic        adc_valid_i,
  input  logic [11:0] adc_sample_i,
  input  logic [7:0]  charger_status_i,
  input  logic [7:0]  fault_events_i,
  input  logic [7:0]  input_state_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        online_o,
  output logic [1:0]  health_o,
  output logic        charging_o,
  output logic [1:0]  charge_status_o,
  output logic [10:0] input_limit_ma_o,
  output logic [4:0]  input_limit_code_o,
  output logic        watchdog_kick_o,
  output logic        charge_restart_o,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  csp_cfg_t    cfg_q;
  csp_state_t  state_q, state_d;
  csp_item_t   item_q;
  csp_result_t result_q, result_d;
  logic        item_valid_q;
  logic        out_valid_q;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  // The result register frees up when empty or when its word is taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.suspended       <= suspended_i;
      item_q.boost_active    <= boost_active_i;
      item_q.port_online     <= port_online_i;
      item_q.port_voltage_mv <= port_voltage_mv_i;
      item_q.port_current_ma <= port_current_ma_i;
      item_q.bc_type         <= bc_type_i;
      item_q.adc_valid       <= adc_valid_i;
      item_q.adc_sample      <= adc_sample_i;
      item_q.charger_status  <= charger_status_i;
      item_q.fault_events    <= fault_events_i;
      item_q.input_state     <= input_state_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  csp_policy u_policy (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Policy state and configuration. The user must write only while the block is idle, so a
  // gadget write that re-arms the floor never meets a tick; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cold_block      <= 12'd400;
      cfg_q.cold_release    <= 12'd800;
      cfg_q.hot_release     <= 12'd2800;
      cfg_q.hot_block       <= 12'd3200;
      cfg_q.gadget_ma       <= 9'd0;
      state_q.thermal_blocked <= 1'b1;
      state_q.charge_enabled  <= 1'b0;
      state_q.power_online    <= 1'b0;
      state_q.health          <= HealthUnknown;
      state_q.limit_ma        <= 11'd0;
      state_q.gadget_cleared  <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end else if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgColdBlock:   cfg_q.cold_block   <= cfg_data_i;
          CfgColdRelease: cfg_q.cold_release <= cfg_data_i;
          CfgHotRelease:  cfg_q.hot_release  <= cfg_data_i;
          CfgHotBlock:    cfg_q.hot_block    <= cfg_data_i;
          CfgGadget: begin
            // Floors whose low nine bits exceed the maximum are dropped and do not re-arm.
            if (cfg_data_i[8:0] <= GadgetMaxMa) begin
              cfg_q.gadget_ma        <= cfg_data_i[8:0];
              state_q.gadget_cleared <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign online_o           = result_q.online;
  assign health_o           = result_q.health;
  assign charging_o         = result_q.charging;
  assign charge_status_o    = result_q.charge_status;
  assign input_limit_ma_o   = result_q.input_limit_ma;
  assign input_limit_code_o = result_q.input_limit_code;
  assign watchdog_kick_o    = result_q.watchdog_kick;
  assign charge_restart_o   = result_q.charge_restart;

  // Charging is only ever enabled on a tick that found the thermal block clear.
  a_charge_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.charge_enabled |-> !state_q.thermal_blocked)
    else $error("charging enabled while thermally blocked");

  // A restart turns charging off first, so the same report cannot carry a kick.
  a_restart_no_kick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(result_q.charge_restart && result_q.watchdog_kick))
    else $error("restart and kick reported together");

  // Kick and restart only accompany a report with charging on.
  a_kick_needs_charging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.watchdog_kick || result_q.charge_restart)) |->
      result_q.charging)
    else $error("kick or restart without charging");

  // A live charge limit is never below the minimum programmable current.
  a_limit_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.charge_enabled |-> (state_q.limit_ma >= MinLimitMa))
    else $error("charging with a limit below the minimum");

endmodule

// File: bench/charger_supervisor_policy_top_tb.sv
// Self-checking testbench for the charger supervisor policy block with a built-in policy mirror.
module charger_supervisor_policy_top_tb
  import csp_pkg::*;
();

  localparam int unsigned ClockPeriod    = 20;
  // Limit on the run length; reaching it ends the run as a failure.
  localparam int unsigned RunLimitCycles = 200_000;

  localparam logic [7:0] StatusPowerGood = 8'h80;
  localparam logic [7:0] DevDcp          = 8'h40;
  localparam logic [7:0] DevCdp          = 8'h20;
  // An index that names no register; the block must ignore writes to it.
  localparam logic [2:0] CfgNoReg        = 3'd7;

  // The mirror keeps its own copy of the thresholds, the gadget floor and the policy
  // state. Every word accepted by the block is run through the same policy here, and
  // the resulting report is queued until the block delivers its own.
  class supervisor_mirror;
    csp_cfg_t    cfg;
    csp_state_t  st;
    csp_result_t pending_reports[$];
    int unsigned report_errors;

    function new();
      cfg = '{cold_block: 12'd400, cold_release: 12'd800, hot_release: 12'd2800,
              hot_block: 12'd3200, gadget_ma: 9'd0};
      st = '0;
      st.thermal_blocked = 1'b1;
      st.health = HealthUnknown;
      report_errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [11:0] data);
      case (idx)
        CfgColdBlock:   cfg.cold_block   = data;
        CfgColdRelease: cfg.cold_release = data;
        CfgHotRelease:  cfg.hot_release  = data;
        CfgHotBlock:    cfg.hot_block    = data;
        CfgGadget: begin
          // Only the low nine bits reach the floor; an oversized value is dropped
          // without re-arming.
          if (data[8:0] <= GadgetMaxMa) begin
            cfg.gadget_ma = data[8:0];
            st.gadget_cleared = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_tick(csp_item_t w);
      csp_result_t r;
      int unsigned ma, floor_ma, lim;
      bit enable, restarted;
      r = '0;
      enable = 1'b0;
      restarted = 1'b0;
      if (!w.suspended && !w.boost_active) begin
        ma = 0;
        if (w.port_online && w.port_voltage_mv == PortVoltageOkMv) begin
          ma = w.port_current_ma;
          if (ma > MaxLimitMa) ma = MaxLimitMa;
          floor_ma = st.gadget_cleared ? 0 : cfg.gadget_ma;
          if ((w.bc_type & DevTypeDcpCdp) != 0) ma = MaxLimitMa;
          else if (floor_ma > GadgetFloorMa && floor_ma > ma) ma = floor_ma;
        end
        if (ma == 0) st.gadget_cleared = 1'b1;
        st.power_online = (ma > 0);
        if (!w.adc_valid) begin
          st.health = HealthUnknown;
        end else begin
          // The block test takes priority over the release window.
          if (w.adc_sample <= cfg.cold_block || w.adc_sample >= cfg.hot_block) begin
            st.thermal_blocked = 1'b1;
          end else if (w.adc_sample >= cfg.cold_release &&
                       w.adc_sample <= cfg.hot_release) begin
            st.thermal_blocked = 1'b0;
          end
          st.health = st.thermal_blocked ? HealthFail : HealthGood;
          st.power_online = (ma > 0) && w.charger_status[7];
          if (st.power_online && !st.thermal_blocked && ma >= MinLimitMa) begin
            if (w.fault_events[3:0] == FaultThermal ||
                w.fault_events[3:0] == FaultOverVolt) begin
              st.health = HealthFail;
            end else begin
              if (w.fault_events[3:0] == FaultWatchdog) begin
                st.charge_enabled = 1'b0;
                restarted = 1'b1;
              end
              if (w.input_state[6:4] != InputStateA && w.input_state[6:4] != InputStateB)
                st.health = HealthFail;
              else
                enable = 1'b1;
            end
          end
        end
        if (enable) begin
          r.watchdog_kick = st.charge_enabled;
          r.charge_restart = restarted;
          st.charge_enabled = 1'b1;
          st.limit_ma = 11'(ma);
        end else begin
          st.charge_enabled = 1'b0;
          st.limit_ma = '0;
        end
      end
      lim = w.boost_active ? 0 : st.limit_ma;
      r.online = st.power_online && !w.boost_active;
      r.health = st.health;
      r.charging = st.charge_enabled;
      if (w.boost_active || !st.power_online) r.charge_status = StDischarging;
      else if (!st.charge_enabled) r.charge_status = StNotCharging;
      else if (w.charger_status[3:0] == StatusFullCode) r.charge_status = StFull;
      else r.charge_status = StCharging;
      r.input_limit_ma = 11'(lim);
      r.input_limit_code = (lim >= MinLimitMa) ? 5'((lim - MinLimitMa) / 50) : 5'd0;
      pending_reports.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        report_errors++;
      end
    endfunction

    function void check_report(csp_result_t got);
      csp_result_t want;
      if (pending_reports.size() == 0) begin
        $error("report word arrived with no tick pending");
        report_errors++;
        return;
      end
      want = pending_reports.pop_front();
      check_field("online", want.online, got.online);
      check_field("health", want.health, got.health);
      check_field("charging", want.charging, got.charging);
      check_field("charge_status", want.charge_status, got.charge_status);
      check_field("input_limit_ma", want.input_limit_ma, got.input_limit_ma);
      check_field("input_limit_code", want.input_limit_code, got.input_limit_code);
      check_field("watchdog_kick", want.watchdog_kick, got.watchdog_kick);
      check_field("charge_restart", want.charge_restart, got.charge_restart);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic        suspended_i        = 1'b0;
  logic        boost_active_i     = 1'b0;
  logic        port_online_i      = 1'b0;
  logic [14:0] port_voltage_mv_i  = '0;
  logic [12:0] port_current_ma_i  = '0;
  logic [7:0]  bc_type_i          = '0;
  logic        adc_valid_i        = 1'b0;
  logic [11:0] adc_sample_i       = '0;
  logic [7:0]  charger_status_i   = '0;
  logic [7:0]  fault_events_i     = '0;
  logic [7:0]  input_state_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic        online_o;
  logic [1:0]  health_o;
  logic        charging_o;
  logic [1:0]  charge_status_o;
  logic [10:0] input_limit_ma_o;
  logic [4:0]  input_limit_code_o;
  logic        watchdog_kick_o;
  logic        charge_restart_o;
  logic        cfg_we_i           = 1'b0;
  logic [2:0]  cfg_idx_i          = '0;
  logic [11:0] cfg_data_i         = '0;

  // When set, the matching side runs back to back so that stretches without gaps occur.
  bit quiet_sender   = 1'b0;
  bit quiet_receiver = 1'b0;

  supervisor_mirror mirror = new();

  charger_supervisor_policy_top dut (.*);

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(ClockPeriod / 2) clk_i = ~clk_i;
  end

  // A nominal charging tick: 5 V port at 500 mA, power good, sample in the middle
  // of the release window, no faults and an accepted input state.
  function automatic csp_item_t good_word();
    csp_item_t w;
    w = '0;
    w.port_online = 1'b1;
    w.port_voltage_mv = PortVoltageOkMv;
    w.port_current_ma = 13'd500;
    w.adc_valid = 1'b1;
    w.adc_sample = 12'((int'(mirror.cfg.cold_release) + int'(mirror.cfg.hot_release)) / 2);
    w.charger_status = StatusPowerGood;
    w.input_state = {1'b0, InputStateA, 4'h0};
    return w;
  endfunction

  // Mostly well-formed ticks with random content aimed at the thresholds, the current
  // corners and the fault codes; about one word in twenty is pure noise.
  function automatic csp_item_t policy_word();
    csp_item_t   w;
    logic [95:0] noise;
    logic [11:0] levels [4];
    int          s;
    w = good_word();
    if ($urandom_range(0, 19) == 0) begin
      noise = {$urandom(), $urandom(), $urandom()};
      w = noise[$bits(csp_item_t)-1:0];
      w.port_voltage_mv = 15'($urandom_range(0, 20000));
      w.port_current_ma = 13'($urandom_range(0, 5000));
      return w;
    end
    levels = '{mirror.cfg.cold_block, mirror.cfg.cold_release,
               mirror.cfg.hot_release, mirror.cfg.hot_block};
    w.suspended = ($urandom_range(0, 24) == 0);
    w.boost_active = ($urandom_range(0, 19) == 0);
    w.port_online = ($urandom_range(0, 14) != 0);
    if ($urandom_range(0, 7) == 0) w.port_voltage_mv = 15'($urandom_range(0, 20000));
    case ($urandom_range(0, 7))
      0: w.port_current_ma = '0;
      1: w.port_current_ma = 13'($urandom_range(1, 99));
      2: w.port_current_ma = 13'($urandom_range(99, 101));
      3: w.port_current_ma = 13'($urandom_range(100, 1500));
      4: w.port_current_ma = 13'($urandom_range(1500, 5000));
      5: w.port_current_ma = 13'($urandom_range(0, 5000));
      6: begin
        s = int'(mirror.cfg.gadget_ma) + int'($urandom_range(0, 2)) - 1;
        w.port_current_ma = 13'((s < 0) ? 0 : s);
      end
      default: w.port_current_ma = 13'($urandom_range(101, 499));
    endcase
    w.bc_type = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) w.bc_type = w.bc_type & ~DevTypeDcpCdp;
    w.adc_valid = ($urandom_range(0, 19) != 0);
    case ($urandom_range(0, 5))
      0: w.adc_sample = 12'($urandom_range(0, 4095));
      1, 2: begin
        // Land right on or next to one of the four levels.
        s = int'(levels[$urandom_range(0, 3)]) + int'($urandom_range(0, 4)) - 2;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        w.adc_sample = 12'(s);
      end
      default: w.adc_sample = 12'($urandom_range(mirror.cfg.cold_release,
                                                 mirror.cfg.hot_release));
    endcase
    w.charger_status = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) != 0) w.charger_status[7] = 1'b1;
    if ($urandom_range(0, 3) == 0) w.charger_status[3:0] = StatusFullCode;
    w.fault_events = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0, 1, 2: w.fault_events[3:0] = 4'h0;
      3:       w.fault_events[3:0] = FaultThermal;
      4:       w.fault_events[3:0] = FaultOverVolt;
      5, 6:    w.fault_events[3:0] = FaultWatchdog;
      default: ;
    endcase
    w.input_state = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) != 0)
      w.input_state[6:4] = ($urandom_range(0, 1) != 0) ? InputStateA : InputStateB;
    return w;
  endfunction

  // Presents one tick word after a random gap and holds it until the block takes it.
  // Valid stays high when the next word follows without a gap.
  task automatic send_word(csp_item_t w);
    int unsigned gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {suspended_i, boost_active_i, port_online_i, port_voltage_mv_i, port_current_ma_i,
     bc_type_i, adc_valid_i, adc_sample_i, charger_status_i, fault_events_i,
     input_state_i} <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    mirror.note_tick(w);
  endtask

  // Stops the sender and waits until every pending report has come back, so the block
  // is idle afterwards.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (mirror.pending_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One register write; the leading edge keeps the enable from being lowered and raised
  // in the same step when writes follow each other.
  task automatic program_reg(logic [2:0] idx, logic [11:0] data);
    @(posedge clk_i);
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mirror.write_reg(idx, data);
  endtask

  // The report side stalls for a random number of cycles before each word it takes.
  initial begin : report_sink
    csp_result_t got;
    int unsigned hold;
    forever begin
      hold = quiet_receiver ? 0 : $urandom_range(0, 9);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = {online_o, health_o, charging_o, charge_status_o, input_limit_ma_o,
             input_limit_code_o, watchdog_kick_o, charge_restart_o};
      mirror.check_report(got);
    end
  end

  initial begin : stimulus
    csp_item_t   w;
    logic [11:0] lv [4];
    logic [11:0] gadget;
    logic [11:0] thermal_walk [5];
    int unsigned words_in_phase;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first good tick clears the reset-time thermal block; the second one kicks the
    // watchdog and reports a full battery.
    w = good_word();
    send_word(w);
    w.charger_status[3:0] = StatusFullCode;
    send_word(w);
    // A watchdog fault restarts charging; the two persistent faults stop it.
    w = good_word();
    w.fault_events[3:0] = FaultWatchdog;
    send_word(w);
    w.fault_events[3:0] = FaultThermal;
    send_word(w);
    w.fault_events[3:0] = FaultOverVolt;
    send_word(w);
    // A rejected input state, then the other accepted state without input power good.
    w = good_word();
    w.input_state = '0;
    send_word(w);
    w = good_word();
    w.input_state[6:4] = InputStateB;
    w.charger_status = '0;
    send_word(w);
    // A failed thermistor read leaves the thermal block as it is.
    w = good_word();
    w.adc_valid = 1'b0;
    send_word(w);
    // Walk the hysteresis: block cold, stay blocked between the edges, release,
    // block hot, release again.
    thermal_walk = '{mirror.cfg.cold_block,
                     12'((int'(mirror.cfg.cold_block) + int'(mirror.cfg.cold_release)) / 2),
                     mirror.cfg.cold_release, mirror.cfg.hot_block, mirror.cfg.hot_release};
    foreach (thermal_walk[i]) begin
      w = good_word();
      w.adc_sample = thermal_walk[i];
      send_word(w);
    end
    // Skipped ticks and ticks that allow no current.
    w = good_word();
    w.suspended = 1'b1;
    send_word(w);
    w = good_word();
    w.boost_active = 1'b1;
    send_word(w);
    w = good_word();
    w.port_online = 1'b0;
    send_word(w);
    w = good_word();
    w.port_voltage_mv = 15'd20000;
    send_word(w);
    w.port_voltage_mv = 15'd4999;
    send_word(w);
    // Current clipping, the DCP and CDP override, and a limit below the minimum.
    w = good_word();
    w.port_current_ma = 13'd5000;
    w.bc_type = ~DevTypeDcpCdp;
    send_word(w);
    w = good_word();
    w.port_current_ma = 13'd100;
    w.bc_type = DevDcp;
    send_word(w);
    w.port_current_ma = 13'd99;
    w.bc_type = DevCdp;
    send_word(w);
    w = good_word();
    w.port_current_ma = 13'd99;
    send_word(w);
    // All ones on a policy tick, then all zeros.
    w = '1;
    w.suspended = 1'b0;
    w.boost_active = 1'b0;
    w.port_voltage_mv = 15'd20000;
    send_word(w);
    w = '0;
    send_word(w);

    // Gadget floor: it lifts a low port current, is cleared by a zero-current tick, and
    // an oversized write neither changes it nor re-arms it.
    drain_reports();
    program_reg(CfgGadget, 12'd500);
    w = good_word();
    w.port_current_ma = 13'd200;
    send_word(w);
    w.port_online = 1'b0;
    send_word(w);
    w.port_online = 1'b1;
    send_word(w);
    drain_reports();
    program_reg(CfgGadget, 12'h1FF);
    w.port_current_ma = 13'd150;
    send_word(w);

    // Random phases, each under its own register setting. Between phases the sender
    // holds off until every report is back.
    for (int p = 0; p < 7; p++) begin
      drain_reports();
      if (p > 0) begin
        lv[0] = 12'($urandom_range(0, 1200));
        lv[1] = lv[0] + 12'($urandom_range(0, 600));
        lv[2] = 12'($urandom_range(2200, 3400));
        lv[3] = lv[2] + 12'($urandom_range(0, 600));
        gadget = 12'($urandom_range(0, 500));
        case (p)
          1: begin
            // Widest release window and the largest floor.
            lv = '{12'd0, 12'd0, 12'd4095, 12'd4095};
            gadget = 12'd500;
          end
          2: begin
            // Every sample blocks; the floor is off.
            lv = '{12'd4095, 12'd4095, 12'd0, 12'd0};
            gadget = 12'd0;
          end
          3: begin
            // Levels in no particular order; a ten-bit floor value of which only nine bits count.
            foreach (lv[i]) lv[i] = 12'($urandom_range(0, 4095));
            gadget = 12'h264;
          end
          4: begin
            gadget = 12'hFFF;
            program_reg(CfgNoReg, 12'hABC);
          end
          default: ;
        endcase
        program_reg(CfgColdBlock, lv[0]);
        program_reg(CfgColdRelease, lv[1]);
        program_reg(CfgHotRelease, lv[2]);
        program_reg(CfgHotBlock, lv[3]);
        program_reg(CfgGadget, gadget);
      end
      quiet_sender = (p % 3 == 1);
      quiet_receiver = (p % 3 == 2);
      words_in_phase = (p == 2) ? 30 : 80;
      repeat (words_in_phase) send_word(policy_word());
    end

    drain_reports();
    if (mirror.report_errors == 0 && mirror.pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : run_limit
    #(RunLimitCycles * ClockPeriod);
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
hdl/csp_pkg.sv
hdl/csp_policy.sv
hdl/charger_supervisor_policy_top.sv
bench/charger_supervisor_policy_top_tb.sv
